>>> design/apsc_pkg.sv
// Shared constants for the alignment path sanity checker.
package apsc_pkg;

  localparam int LEN_BITS_DEFAULT = 32;

  localparam int OP_W     = 3;
  localparam int STATUS_W = 3;
  localparam int SPAN_W   = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 40;
  localparam int EXP_LEN_W  = 32;
  localparam int REF_LEN_W  = 32;
  localparam int POS_W      = 40;

  localparam logic [SPAN_W-1:0] SPAN_MAX = '1;

  typedef enum logic [OP_W-1:0] {
    OP_MATCH    = 3'd0,
    OP_EQUAL    = 3'd1,
    OP_MISMATCH = 3'd2,
    OP_INS      = 3'd3,
    OP_DEL      = 3'd4,
    OP_CLIP     = 3'd5,
    OP_RSVD6    = 3'd6,
    OP_RSVD7    = 3'd7
  } edit_op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_INDEL      = 3'd1,
    ST_READ_LEN   = 3'd2,
    ST_TOO_LONG   = 3'd3,
    ST_OUT_BOUNDS = 3'd4
  } status_t;

  localparam logic [CFG_IDX_W-1:0] REG_READ_CHECK_EN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXP_READ_LEN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REF_CHECK_EN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REF_LEN       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REF_START     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HIT_POS       = 3'd5;

  typedef struct packed {
    logic step;
    logic last;
  } tally_ctl_t;

endpackage

>>> design/apsc_tally.sv
// Path state: saturating read and reference counters, previous operation and indel flag.
module apsc_tally #(
  parameter int LEN_BITS = apsc_pkg::LEN_BITS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  apsc_pkg::tally_ctl_t ctl,
  input  apsc_pkg::edit_op_t  op,
  output logic [LEN_BITS-1:0] read_cnt,
  output logic [LEN_BITS-1:0] ref_cnt,
  output logic                indel
);

  apsc_pkg::edit_op_t  prev_op_r;
  logic                prev_valid_r;
  logic [LEN_BITS-1:0] read_cnt_r;
  logic [LEN_BITS-1:0] ref_cnt_r;
  logic                indel_r;

  logic on_read;
  logic on_ref;

  always_comb begin
    on_read = (op == apsc_pkg::OP_MATCH) || (op == apsc_pkg::OP_EQUAL) ||
              (op == apsc_pkg::OP_MISMATCH) || (op == apsc_pkg::OP_INS) ||
              (op == apsc_pkg::OP_CLIP);
    on_ref  = (op == apsc_pkg::OP_MATCH) || (op == apsc_pkg::OP_EQUAL) ||
              (op == apsc_pkg::OP_MISMATCH) || (op == apsc_pkg::OP_DEL);
    read_cnt = (on_read && (read_cnt_r != '1)) ? read_cnt_r + LEN_BITS'(1) : read_cnt_r;
    ref_cnt  = (on_ref && (ref_cnt_r != '1)) ? ref_cnt_r + LEN_BITS'(1) : ref_cnt_r;
    indel    = indel_r ||
               (prev_valid_r &&
                (((prev_op_r == apsc_pkg::OP_INS) && (op == apsc_pkg::OP_DEL)) ||
                 ((prev_op_r == apsc_pkg::OP_DEL) && (op == apsc_pkg::OP_INS))));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_op_r    <= apsc_pkg::OP_MATCH;
      prev_valid_r <= 1'b0;
      read_cnt_r   <= '0;
      ref_cnt_r    <= '0;
      indel_r      <= 1'b0;
    end else if (ctl.step) begin
      if (ctl.last) begin
        prev_op_r    <= apsc_pkg::OP_MATCH;
        prev_valid_r <= 1'b0;
        read_cnt_r   <= '0;
        ref_cnt_r    <= '0;
        indel_r      <= 1'b0;
      end else begin
        prev_op_r    <= op;
        prev_valid_r <= 1'b1;
        read_cnt_r   <= read_cnt;
        ref_cnt_r    <= ref_cnt;
        indel_r      <= indel;
      end
    end
  end

endmodule

>>> design/alignment_path_sanity_checker_core.sv
// Top level of the alignment path sanity checker.
//
//   Channel  Direction  Transaction
//   in_      slave      one edit operation, in_tlast marks the end of a path
//   out_     master     one status word and two spans per path
//   cfg_     write      one register write per cycle with cfg_we high
//
// An operation enters an input register and is folded into the path counters as it
// leaves that register, and a path's result lands in the output register at that edge.
// One operation per cycle is accepted unless a final operation is waiting.
// Only a final operation waits when the output register is full and stalled.
// Reset clears the path state, the configuration registers and both valid flags.
module alignment_path_sanity_checker_core #(
  parameter int LEN_BITS = apsc_pkg::LEN_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [2:0] edit_op, rest zero
  input  logic        in_tlast,   // last_op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [2:0] status, [34:3] read_span, [66:35] ref_span
  input  logic                             cfg_we,
  input  logic [apsc_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [apsc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int CW = ((LEN_BITS > apsc_pkg::POS_W) ? LEN_BITS : apsc_pkg::POS_W) + 1;

  logic                              read_en_r;
  logic [apsc_pkg::EXP_LEN_W-1:0]    exp_len_r;
  logic                              ref_en_r;
  logic [apsc_pkg::REF_LEN_W-1:0]    ref_len_r;
  logic [apsc_pkg::POS_W-1:0]        seq_base_r;
  logic [apsc_pkg::POS_W-1:0]        hit_pos_r;

  logic               s1_valid_r;
  apsc_pkg::edit_op_t s1_op_r;
  logic               s1_last_r;

  logic                            out_valid_r;
  apsc_pkg::status_t               status_r;
  logic [apsc_pkg::SPAN_W-1:0]     read_span_r;
  logic [apsc_pkg::SPAN_W-1:0]     ref_span_r;

  apsc_pkg::tally_ctl_t  ctl;
  logic [LEN_BITS-1:0]   read_cnt;
  logic [LEN_BITS-1:0]   ref_cnt;
  logic                  indel;
  logic                  out_free;
  logic                  s1_adv;

  logic [CW-1:0]               read_ext;
  logic [CW-1:0]               ref_ext;
  logic [CW-1:0]               span_end;
  logic [CW-1:0]               ref_end;
  apsc_pkg::status_t           status_nxt;
  logic [apsc_pkg::SPAN_W-1:0] read_span_nxt;
  logic [apsc_pkg::SPAN_W-1:0] ref_span_nxt;

  assign out_free  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && (!s1_last_r || out_free);
  assign in_tready = !s1_valid_r || s1_adv;
  assign ctl.step  = s1_adv;
  assign ctl.last  = s1_last_r;

  apsc_tally #(
    .LEN_BITS(LEN_BITS)
  ) u_tally (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .op      (s1_op_r),
    .read_cnt(read_cnt),
    .ref_cnt (ref_cnt),
    .indel   (indel)
  );

  always_comb begin
    read_ext = CW'(read_cnt);
    ref_ext  = CW'(ref_cnt);
    span_end = CW'(hit_pos_r) + ref_ext;
    ref_end  = CW'(seq_base_r) + CW'(ref_len_r);
    read_span_nxt = (read_ext > CW'(apsc_pkg::SPAN_MAX)) ? apsc_pkg::SPAN_MAX
                                                         : read_ext[apsc_pkg::SPAN_W-1:0];
    ref_span_nxt  = (ref_ext > CW'(apsc_pkg::SPAN_MAX)) ? apsc_pkg::SPAN_MAX
                                                        : ref_ext[apsc_pkg::SPAN_W-1:0];
    priority if (indel) begin
      status_nxt = apsc_pkg::ST_INDEL;
    end else if (read_en_r && (read_ext != CW'(exp_len_r))) begin
      status_nxt = apsc_pkg::ST_READ_LEN;
    end else if (ref_en_r && (ref_ext > CW'(ref_len_r))) begin
      status_nxt = apsc_pkg::ST_TOO_LONG;
    end else if (ref_en_r && (span_end > ref_end)) begin
      status_nxt = apsc_pkg::ST_OUT_BOUNDS;
    end else begin
      status_nxt = apsc_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      read_en_r   <= 1'b0;
      exp_len_r   <= '0;
      ref_en_r    <= 1'b0;
      ref_len_r   <= '0;
      seq_base_r  <= '0;
      hit_pos_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        apsc_pkg::REG_READ_CHECK_EN: read_en_r   <= cfg_wdata[0];
        apsc_pkg::REG_EXP_READ_LEN:  exp_len_r   <= cfg_wdata[apsc_pkg::EXP_LEN_W-1:0];
        apsc_pkg::REG_REF_CHECK_EN:  ref_en_r    <= cfg_wdata[0];
        apsc_pkg::REG_REF_LEN:       ref_len_r   <= cfg_wdata[apsc_pkg::REF_LEN_W-1:0];
        apsc_pkg::REG_REF_START:     seq_base_r  <= cfg_wdata[apsc_pkg::POS_W-1:0];
        apsc_pkg::REG_HIT_POS:       hit_pos_r   <= cfg_wdata[apsc_pkg::POS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_op_r   <= apsc_pkg::edit_op_t'(in_tdata[apsc_pkg::OP_W-1:0]);
      s1_last_r <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last_r) begin
      status_r    <= status_nxt;
      read_span_r <= read_span_nxt;
      ref_span_r  <= ref_span_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, ref_span_r, read_span_r, status_r};

endmodule
